[sv/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/hbd2_pkg.sv]
// Types and constants of the halfband decimate-by-two filter.
`timescale 1ns / 1ps
package hbd2_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int NUM_REGS   = 7;
    localparam int REG_IDX_W  = 3;
    localparam int FRAC_SHIFT = COEF_W - 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic [REG_IDX_W-1:0]       t_reg_idx;

    // Register map
    localparam t_reg_idx REG_EVEN_TAP_0 = 3'd0;
    localparam t_reg_idx REG_MID_TAP    = 3'd6;

    // Round to nearest, then saturate to the sample range
    localparam t_acc ROUND_BIAS = t_acc'(1) <<< (COEF_W - 3);
    localparam t_acc SAT_HI     = t_acc'((2 ** (SAMPLE_W - 1)) - 1);
    localparam t_acc SAT_LO     = t_acc'(-(2 ** (SAMPLE_W - 1)));
    localparam t_sample SAMPLE_MAX = t_sample'((2 ** (SAMPLE_W - 1)) - 1);
    localparam t_sample SAMPLE_MIN = t_sample'(-(2 ** (SAMPLE_W - 1)));

endpackage

[sv/halfband_decimator_by_two_top.sv]
// Halfband decimate-by-two filter, polyphase, single pass, one request per cycle unless the output waits unread.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  input    | in        | i_in_valid / o_in_ready    | i_even_sample, i_odd_sample
//  output   | out       | o_out_valid / i_out_ready  | o_filtered_sample
//  config   | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One request per cycle sustained while results are read; o_out_valid rises once an accepted request has
// passed the input register and the output register. Input register is the sample line; products, sum, round and
// saturate feed the output register. o_in_ready drops only while the input stage holds a request and the output
// waits unread. Synchronous active-low reset clears valids, coefficients and sample history.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module halfband_decimator_by_two_top #(
    parameter int PROTO_TAPS = 11,
    parameter int ODD_DELAY  = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  hbd2_pkg::t_reg_idx        i_cfg_idx,
    input  logic [hbd2_pkg::COEF_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  hbd2_pkg::t_sample         i_even_sample,
    input  hbd2_pkg::t_sample         i_odd_sample,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output hbd2_pkg::t_sample         o_filtered_sample
);
    import hbd2_pkg::*;

    localparam int EVEN_TAPS = (PROTO_TAPS + 1) / 2;

    t_coef   r_coef [NUM_REGS];
    t_sample r_even_line [EVEN_TAPS];
    t_sample r_odd_line [ODD_DELAY+1];
    t_prod   w_prod [EVEN_TAPS+1];
    t_acc    w_sum;
    t_acc    w_rnd;
    t_acc    w_shift;
    t_sample r_out;
    t_sample n_out;

    logic r_in_valid;
    logic r_out_valid;
    logic w_free_out;
    logic w_move;
    logic w_accept;

    // Handshake
    assign w_free_out = !r_out_valid || i_out_ready;
    assign w_move     = r_in_valid && w_free_out;
    assign o_in_ready = !r_in_valid || w_free_out;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= w_accept || (r_in_valid && !w_move);
            r_out_valid <= w_move || (r_out_valid && !i_out_ready);
        end
    end

    // Coefficients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx <= REG_MID_TAP)) begin
            r_coef[i_cfg_idx] <= t_coef'(i_cfg_data);
        end
    end

    // Sample history; after a shift the line holds the taps of that request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < EVEN_TAPS; k++) begin
                r_even_line[k] <= '0;
            end
            for (int k = 0; k <= ODD_DELAY; k++) begin
                r_odd_line[k] <= '0;
            end
        end else if (w_accept) begin
            r_even_line[0] <= i_even_sample;
            for (int k = 1; k < EVEN_TAPS; k++) begin
                r_even_line[k] <= r_even_line[k-1];
            end
            r_odd_line[0] <= i_odd_sample;
            for (int k = 1; k <= ODD_DELAY; k++) begin
                r_odd_line[k] <= r_odd_line[k-1];
            end
        end
    end

    // Products
    always_comb begin
        for (int i = 0; i < EVEN_TAPS; i++) begin
            w_prod[i] = r_coef[REG_EVEN_TAP_0 + t_reg_idx'(i)] * r_even_line[i];
        end
        w_prod[EVEN_TAPS] = r_coef[REG_MID_TAP] * r_odd_line[ODD_DELAY];
    end

    // Total
    always_comb begin
        w_sum = '0;
        for (int i = 0; i <= EVEN_TAPS; i++) begin
            w_sum = w_sum + t_acc'(w_prod[i]);
        end
    end

    // Double, round, saturate
    assign w_rnd   = w_sum + ROUND_BIAS;
    assign w_shift = w_rnd >>> FRAC_SHIFT;

    always_comb begin
        if (w_shift > SAT_HI) begin
            n_out = SAMPLE_MAX;
        end else if (w_shift < SAT_LO) begin
            n_out = SAMPLE_MIN;
        end else begin
            n_out = w_shift[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out;

    `ASSERT_NEXT(a_accept_fills, w_accept, r_in_valid, "accepted request not in input stage")
    `ASSERT_IMPL(a_ready_means_full, !o_in_ready,
        r_in_valid && r_out_valid && !i_out_ready, "input blocked with room in pipeline")
    `ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_filtered_sample), "waiting output changed or dropped")
    `ASSERT_NEXT(a_sat_hi, w_move && (w_shift > SAT_HI),
        r_out == SAMPLE_MAX, "positive overflow not saturated")

endmodule

[bench/tb_halfband_decimator_by_two_top.sv]
// Self-checking testbench for the halfband decimate-by-two filter top level.
`timescale 1ns / 1ps
module tb_halfband_decimator_by_two_top;
    import hbd2_pkg::*;

    localparam int PROTO_TAPS = 11;
    localparam int ODD_DELAY  = 3;
    localparam int EVEN_TAPS  = (PROTO_TAPS + 1) / 2;
    localparam int EVEN_DEPTH = 5;
    localparam int ODD_DEPTH  = 3;
    localparam int STALL_LIMIT = 2000;
    localparam int SEG_PAIRS  = 100;
    localparam t_reg_idx REG_UNUSED = t_reg_idx'(NUM_REGS);

    class decimator_scoreboard;
        t_coef   coef [NUM_REGS];
        t_sample even_hist [EVEN_DEPTH];
        t_sample odd_hist [ODD_DEPTH];
        t_sample filtered_due [$];
        int      mismatches;
        int      pairs_noted;
        int      results_checked;

        function new();
            foreach (coef[i]) coef[i] = '0;
            foreach (even_hist[i]) even_hist[i] = '0;
            foreach (odd_hist[i]) odd_hist[i] = '0;
            mismatches = 0;
            pairs_noted = 0;
            results_checked = 0;
        endfunction

        function void set_coef(t_reg_idx idx, t_coef value);
            if (idx < NUM_REGS) coef[idx] = value;
        endfunction

        function t_sample predict_filtered(t_sample even_in, t_sample odd_in);
            longint acc;
            longint rounded;
            acc = longint'(coef[REG_EVEN_TAP_0]) * longint'(even_in);
            for (int k = 1; k < EVEN_TAPS && k <= EVEN_DEPTH; k++)
                acc += longint'(coef[k]) * longint'(even_hist[k-1]);
            acc += longint'(coef[REG_MID_TAP]) * longint'(odd_hist[ODD_DELAY-1]);
            // doubling folded into the shift; ties go toward +inf
            rounded = (acc + (longint'(1) <<< (COEF_W - 3))) >>> FRAC_SHIFT;
            if (rounded > longint'(SAMPLE_MAX)) rounded = longint'(SAMPLE_MAX);
            if (rounded < longint'(SAMPLE_MIN)) rounded = longint'(SAMPLE_MIN);
            for (int k = EVEN_DEPTH - 1; k > 0; k--) even_hist[k] = even_hist[k-1];
            even_hist[0] = even_in;
            for (int k = ODD_DEPTH - 1; k > 0; k--) odd_hist[k] = odd_hist[k-1];
            odd_hist[0] = odd_in;
            return t_sample'(rounded);
        endfunction

        function void note_pair(t_sample even_in, t_sample odd_in);
            filtered_due.push_back(predict_filtered(even_in, odd_in));
            pairs_noted++;
        endfunction

        function void check_filtered(t_sample actual);
            t_sample want;
            if (filtered_due.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual %0d", $time, actual);
                mismatches++;
            end else begin
                want = filtered_due.pop_front();
                results_checked++;
                if (want !== actual) begin
                    $display("%0t: filtered_sample expected %0d, actual %0d",
                             $time, want, actual);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return filtered_due.size();
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_reg_idx i_cfg_idx;
    logic [COEF_W-1:0] i_cfg_data;
    logic     i_in_valid;
    logic     o_in_ready;
    t_sample  i_even_sample;
    t_sample  i_odd_sample;
    logic     o_out_valid;
    logic     i_out_ready;
    t_sample  o_filtered_sample;

    decimator_scoreboard sb = new();
    int    send_idle_pct;
    int    recv_idle_pct;
    int    stall_cycles;
    int    coef_sets;
    t_coef tap_plan [NUM_REGS];

    halfband_decimator_by_two_top #(
        .PROTO_TAPS (PROTO_TAPS),
        .ODD_DELAY  (ODD_DELAY)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_even_sample     (i_even_sample),
        .i_odd_sample      (i_odd_sample),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_filtered_sample (o_filtered_sample)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: check on each accepted result, then pick next ready
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_filtered(o_filtered_sample);
            i_out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_pair(input t_sample even_in, input t_sample odd_in);
        if (int'($urandom_range(99)) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (int'($urandom_range(99)) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_even_sample <= even_in;
        i_odd_sample  <= odd_in;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pair(even_in, odd_in);
    endtask

    // hold off input until every expected output is back
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic program_taps(input bit poke_unused);
        for (int r = 0; r < NUM_REGS; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_reg_idx'(r);
            i_cfg_data <= tap_plan[r];
            @(posedge i_clk);
            sb.set_coef(t_reg_idx'(r), tap_plan[r]);
        end
        if (poke_unused) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_UNUSED;
            i_cfg_data <= COEF_W'($urandom);
            @(posedge i_clk);
            sb.set_coef(REG_UNUSED, t_coef'(i_cfg_data));
        end
        i_cfg_we <= 1'b0;
        coef_sets++;
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return t_sample'(int'($urandom_range(2047)) - 1024);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_coef rand_coef();
        case ($urandom_range(9))
            0: return t_coef'(SAMPLE_MAX);
            1: return t_coef'(SAMPLE_MIN);
            2: return '0;
            3, 4: return t_coef'($urandom);
            default: return t_coef'(int'($urandom_range(8191)) - 4096);
        endcase
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_even_sample <= '0;
        i_odd_sample  <= '0;
        send_idle_pct = 28;
        recv_idle_pct = 46;
        coef_sets = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-scale taps: saturation both ways
        foreach (tap_plan[i]) tap_plan[i] = t_coef'(SAMPLE_MAX);
        program_taps(1'b1);
        repeat (4) send_pair(SAMPLE_MAX, SAMPLE_MAX);
        repeat (4) send_pair(SAMPLE_MIN, SAMPLE_MIN);
        drain_outputs();

        // quarter-scale newest tap for rounding ties, negative full centre tap
        foreach (tap_plan[i]) tap_plan[i] = '0;
        tap_plan[REG_EVEN_TAP_0] = t_coef'(8192);
        tap_plan[REG_MID_TAP]    = t_coef'(SAMPLE_MIN);
        program_taps(1'b0);
        send_pair(t_sample'(1), '0);
        send_pair(t_sample'(-1), '0);
        send_pair(t_sample'(3), SAMPLE_MIN);
        send_pair(t_sample'(-3), SAMPLE_MAX);
        send_pair(SAMPLE_MIN, t_sample'(1));
        repeat (3) send_pair('0, '0);
        drain_outputs();

        foreach (tap_plan[i]) tap_plan[i] = t_coef'(SAMPLE_MIN);
        program_taps(1'b1);
        repeat (4) send_pair(SAMPLE_MIN, SAMPLE_MIN);
        repeat (2) send_pair(SAMPLE_MAX, SAMPLE_MIN);

        for (int seg = 0; seg < 6; seg++) begin
            drain_outputs();
            send_idle_pct = (seg < 2) ? 28 : (seg < 4) ? 46 : 0;
            recv_idle_pct = (seg < 2) ? 46 : (seg < 4) ? 28 : 0;
            foreach (tap_plan[i]) tap_plan[i] = rand_coef();
            program_taps(seg[0]);
            repeat (SEG_PAIRS) send_pair(rand_sample(), rand_sample());
        end

        drain_outputs();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d sample pairs over %0d coefficient sets, %0d outputs checked.",
                 sb.pairs_noted, coef_sets, sb.results_checked);
        $display("Covered saturation, rounding ties, unused register writes and back-pressure.");
        if (sb.pending() != 0)
            $display("%0t: %0d expected outputs never arrived", $time, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
